FILE: rtl/core/mtep_pkg.sv
// Shared types, codes and helpers for the MIDI track event parser.
package mtep_pkg;

  // Parser phase within one track event
  typedef enum logic [3:0] {
    PH_DELTA  = 4'd0,
    PH_STATUS = 4'd1,
    PH_DATA1  = 4'd2,
    PH_DATA2  = 4'd3,
    PH_MTYPE  = 4'd4,
    PH_LEN    = 4'd5,
    PH_PARAM  = 4'd6
  } phase_t;

  // Result kinds
  localparam logic [2:0] KIND_CHANNEL = 3'd0;
  localparam logic [2:0] KIND_META    = 3'd1;
  localparam logic [2:0] KIND_SYSEX   = 3'd2;
  localparam logic [2:0] KIND_PARAM   = 3'd3;
  localparam logic [2:0] KIND_ERROR   = 3'd4;

  // Error codes
  localparam logic [1:0] ERR_NONE      = 2'd0;
  localparam logic [1:0] ERR_NO_RUN    = 2'd1;
  localparam logic [1:0] ERR_BAD_STAT  = 2'd2;
  localparam logic [1:0] ERR_TRUNC     = 2'd3;

  // Special status and meta type bytes
  localparam logic [7:0] STAT_META     = 8'hFF;
  localparam logic [7:0] STAT_SYSEX    = 8'hF0;
  localparam logic [7:0] STAT_ESCAPE   = 8'hF7;
  localparam logic [7:0] STAT_SYSTEM   = 8'hF0;
  localparam logic [7:0] META_EOT      = 8'h2F;

  // Minimum bytes that must follow a delta time
  localparam logic [31:0] MIN_TAIL     = 32'd3;

  // One result transaction
  typedef struct packed {
    logic [2:0]  result_kind;
    logic [31:0] delta_ticks;
    logic [31:0] tick_position;
    logic [7:0]  status_byte;
    logic [7:0]  data_one;
    logic [7:0]  data_two;
    logic [31:0] param_length;
    logic [7:0]  param_byte;
    logic        last_of_event;
    logic        end_of_track;
    logic [1:0]  error_code;
  } result_t;

  // Channel messages with two data bytes: note off/on, poly pressure,
  // controller, pitch bend
  function automatic logic has_two_data(input logic [7:0] status);
    logic [3:0] hi;
    hi = status[7:4];
    case (hi)
      4'h8, 4'h9, 4'hA, 4'hB, 4'hE: has_two_data = 1'b1;
      default:                      has_two_data = 1'b0;
    endcase
  endfunction

  function automatic logic is_eot(input logic [7:0] status, input logic [7:0] mtype);
    is_eot = (status == STAT_META) && (mtype == META_EOT);
  endfunction

endpackage

FILE: rtl/core/midi_track_event_parser_unit.sv
// MIDI track event parser: byte-wide track decoder with registered result.
// A result appears on the output in the cycle after the byte that completes it.
// Throughput: one byte per cycle; a byte is taken whenever the result register is
// empty or being drained in the same cycle.
// Reset (synchronous, active high) empties the result register and returns the parser
// to a zero-length track; a configuration write restarts parsing with the new length.
module midi_track_event_parser_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [31:0] cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  data_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  result_kind,
  output logic [31:0] delta_ticks,
  output logic [31:0] tick_position,
  output logic [7:0]  status_byte,
  output logic [7:0]  data_one,
  output logic [7:0]  data_two,
  output logic [31:0] param_length,
  output logic [7:0]  param_byte,
  output logic        last_of_event,
  output logic        end_of_track,
  output logic [1:0]  error_code
);

  // Parser state
  mtep_pkg::phase_t phase, phase_next;
  logic [7:0]  running_status, running_status_next;
  logic [7:0]  current_status, current_status_next;
  logic [7:0]  first_data, first_data_next;
  logic [31:0] vlq_acc, vlq_acc_next;
  logic [31:0] delta_hold, delta_hold_next;
  logic [31:0] tick_count, tick_count_next;
  logic [31:0] bytes_left, bytes_left_next;
  logic [31:0] param_remaining, param_remaining_next;
  logic [31:0] param_total, param_total_next;
  logic        halted, halted_next;

  // Result register
  mtep_pkg::result_t res, res_q;
  logic              res_fire;

  logic        cfg_write;
  logic        in_accept;
  logic [31:0] vlq_new;
  logic [31:0] bytes_dec;
  logic [31:0] rem_dec;

  assign cfg_ready = 1'b1;
  assign cfg_write = cfg_valid && cfg_ready;
  assign in_ready  = !out_valid || out_ready;
  assign in_accept = in_valid && in_ready;

  // Shared datapath terms
  assign vlq_new   = {vlq_acc[24:0], data_byte[6:0]};
  assign bytes_dec = bytes_left - 32'd1;
  assign rem_dec   = (param_remaining != 32'd0) ? (param_remaining - 32'd1) : 32'd0;

  // Result of the byte being taken
  always_comb begin
    res      = '0;
    res_fire = 1'b0;
    if (in_accept && !halted) begin
      if (bytes_left == 32'd0) begin
        res_fire       = 1'b1;
        res.result_kind = mtep_pkg::KIND_ERROR;
        res.last_of_event = 1'b1;
        res.error_code  = mtep_pkg::ERR_TRUNC;
      end else begin
        // common event fields; overridden below for errors
        res.delta_ticks   = delta_hold;
        res.tick_position = tick_count;
        res.status_byte   = current_status;
        res.data_one      = first_data;
        case (phase)
          mtep_pkg::PH_DELTA: begin
            if (!data_byte[7] && (bytes_dec < mtep_pkg::MIN_TAIL)) begin
              res_fire = 1'b1;
              res      = '0;
              res.result_kind   = mtep_pkg::KIND_ERROR;
              res.last_of_event = 1'b1;
              res.error_code    = mtep_pkg::ERR_TRUNC;
            end
          end
          mtep_pkg::PH_STATUS: begin
            if (!data_byte[7]) begin
              if (running_status == 8'd0) begin
                res_fire = 1'b1;
                res      = '0;
                res.result_kind   = mtep_pkg::KIND_ERROR;
                res.last_of_event = 1'b1;
                res.error_code    = mtep_pkg::ERR_NO_RUN;
              end else if (!mtep_pkg::has_two_data(running_status)) begin
                res_fire = 1'b1;
                res.result_kind   = mtep_pkg::KIND_CHANNEL;
                res.status_byte   = running_status;
                res.data_one      = data_byte;
                res.last_of_event = 1'b1;
              end
            end else if ((data_byte >= mtep_pkg::STAT_SYSTEM) &&
                         (data_byte != mtep_pkg::STAT_META) &&
                         (data_byte != mtep_pkg::STAT_SYSEX) &&
                         (data_byte != mtep_pkg::STAT_ESCAPE)) begin
              res_fire = 1'b1;
              res      = '0;
              res.result_kind   = mtep_pkg::KIND_ERROR;
              res.last_of_event = 1'b1;
              res.error_code    = mtep_pkg::ERR_BAD_STAT;
            end
          end
          mtep_pkg::PH_DATA1: begin
            if (!mtep_pkg::has_two_data(current_status)) begin
              res_fire = 1'b1;
              res.result_kind   = mtep_pkg::KIND_CHANNEL;
              res.data_one      = data_byte;
              res.last_of_event = 1'b1;
            end
          end
          mtep_pkg::PH_DATA2: begin
            res_fire = 1'b1;
            res.result_kind   = mtep_pkg::KIND_CHANNEL;
            res.data_two      = data_byte;
            res.last_of_event = 1'b1;
          end
          mtep_pkg::PH_MTYPE: begin
            res_fire = 1'b0;
          end
          mtep_pkg::PH_LEN: begin
            if (!data_byte[7]) begin
              res_fire = 1'b1;
              if (vlq_new > bytes_dec) begin
                res = '0;
                res.result_kind   = mtep_pkg::KIND_ERROR;
                res.last_of_event = 1'b1;
                res.error_code    = mtep_pkg::ERR_TRUNC;
              end else begin
                res.result_kind   = (current_status == mtep_pkg::STAT_META) ?
                                    mtep_pkg::KIND_META : mtep_pkg::KIND_SYSEX;
                res.param_length  = vlq_new;
                res.last_of_event = (vlq_new == 32'd0);
                res.end_of_track  = mtep_pkg::is_eot(current_status, first_data);
              end
            end
          end
          mtep_pkg::PH_PARAM: begin
            res_fire = 1'b1;
            res.result_kind   = mtep_pkg::KIND_PARAM;
            res.param_length  = param_total;
            res.param_byte    = data_byte;
            res.last_of_event = (rem_dec == 32'd0);
            res.end_of_track  = mtep_pkg::is_eot(current_status, first_data);
          end
          default: begin
            res_fire = 1'b1;
            res      = '0;
            res.result_kind   = mtep_pkg::KIND_ERROR;
            res.last_of_event = 1'b1;
            res.error_code    = mtep_pkg::ERR_BAD_STAT;
          end
        endcase
      end
    end
  end

  // Next parser state
  always_comb begin
    phase_next           = phase;
    running_status_next  = running_status;
    current_status_next  = current_status;
    first_data_next      = first_data;
    vlq_acc_next         = vlq_acc;
    delta_hold_next      = delta_hold;
    tick_count_next      = tick_count;
    bytes_left_next      = bytes_left;
    param_remaining_next = param_remaining;
    param_total_next     = param_total;
    halted_next          = halted;
    if (in_accept && !halted && (bytes_left != 32'd0)) begin
      bytes_left_next = bytes_dec;
      case (phase)
        mtep_pkg::PH_DELTA: begin
          vlq_acc_next = vlq_new;
          if (!data_byte[7] && (bytes_dec >= mtep_pkg::MIN_TAIL)) begin
            delta_hold_next = vlq_new;
            tick_count_next = tick_count + vlq_new;
            vlq_acc_next    = 32'd0;
            phase_next      = mtep_pkg::PH_STATUS;
          end
        end
        mtep_pkg::PH_STATUS: begin
          if (!data_byte[7]) begin
            if (running_status != 8'd0) begin
              current_status_next = running_status;
              first_data_next     = data_byte;
              if (mtep_pkg::has_two_data(running_status)) begin
                phase_next = mtep_pkg::PH_DATA2;
              end
            end
          end else if (data_byte < mtep_pkg::STAT_SYSTEM) begin
            running_status_next = data_byte;
            current_status_next = data_byte;
            phase_next          = mtep_pkg::PH_DATA1;
          end else begin
            running_status_next = 8'd0;
            current_status_next = data_byte;
            first_data_next     = 8'd0;
            vlq_acc_next        = 32'd0;
            if (data_byte == mtep_pkg::STAT_META) begin
              phase_next = mtep_pkg::PH_MTYPE;
            end else if ((data_byte == mtep_pkg::STAT_SYSEX) ||
                         (data_byte == mtep_pkg::STAT_ESCAPE)) begin
              phase_next = mtep_pkg::PH_LEN;
            end
          end
        end
        mtep_pkg::PH_DATA1: begin
          first_data_next = data_byte;
          if (mtep_pkg::has_two_data(current_status)) begin
            phase_next = mtep_pkg::PH_DATA2;
          end
        end
        mtep_pkg::PH_MTYPE: begin
          first_data_next = data_byte;
          vlq_acc_next    = 32'd0;
          phase_next      = mtep_pkg::PH_LEN;
        end
        mtep_pkg::PH_LEN: begin
          vlq_acc_next = vlq_new;
          if (!data_byte[7] && (vlq_new <= bytes_dec)) begin
            param_total_next     = vlq_new;
            param_remaining_next = vlq_new;
            phase_next           = mtep_pkg::PH_PARAM;
          end
        end
        mtep_pkg::PH_PARAM: begin
          param_remaining_next = rem_dec;
        end
        default: begin
          phase_next = phase;
        end
      endcase
    end
    // End of an event returns to delta time; errors and end of track halt
    if (res_fire) begin
      if (res.result_kind == mtep_pkg::KIND_ERROR) begin
        halted_next = 1'b1;
      end else if (res.last_of_event) begin
        phase_next   = mtep_pkg::PH_DELTA;
        vlq_acc_next = 32'd0;
        if (res.end_of_track) begin
          halted_next = 1'b1;
        end
      end
    end
  end

  // State registers; a configuration write restarts the track
  always_ff @(posedge clk) begin
    if (rst || cfg_write) begin
      phase           <= mtep_pkg::PH_DELTA;
      running_status  <= 8'd0;
      current_status  <= 8'd0;
      first_data      <= 8'd0;
      vlq_acc         <= 32'd0;
      delta_hold      <= 32'd0;
      tick_count      <= 32'd0;
      bytes_left      <= rst ? 32'd0 : cfg_data;
      param_remaining <= 32'd0;
      param_total     <= 32'd0;
      halted          <= 1'b0;
    end else begin
      phase           <= phase_next;
      running_status  <= running_status_next;
      current_status  <= current_status_next;
      first_data      <= first_data_next;
      vlq_acc         <= vlq_acc_next;
      delta_hold      <= delta_hold_next;
      tick_count      <= tick_count_next;
      bytes_left      <= bytes_left_next;
      param_remaining <= param_remaining_next;
      param_total     <= param_total_next;
      halted          <= halted_next;
    end
  end

  // Result register valid
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_accept) begin
      out_valid <= res_fire;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // Result register payload
  always_ff @(posedge clk) begin
    if (in_accept && res_fire) begin
      res_q <= res;
    end
  end

  assign result_kind   = res_q.result_kind;
  assign delta_ticks   = res_q.delta_ticks;
  assign tick_position = res_q.tick_position;
  assign status_byte   = res_q.status_byte;
  assign data_one      = res_q.data_one;
  assign data_two      = res_q.data_two;
  assign param_length  = res_q.param_length;
  assign param_byte    = res_q.param_byte;
  assign last_of_event = res_q.last_of_event;
  assign end_of_track  = res_q.end_of_track;
  assign error_code    = res_q.error_code;

`ifndef ASSERT_OFF
  // Error results close the event and carry a real code
  a_err_shape: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (result_kind == mtep_pkg::KIND_ERROR)) |->
      (last_of_event && (error_code != mtep_pkg::ERR_NONE)))
    else $error("error result without last flag or code");

  // Non-error results carry no error code
  a_no_code: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (result_kind != mtep_pkg::KIND_ERROR)) |->
      (error_code == mtep_pkg::ERR_NONE))
    else $error("error code on a normal result");

  // A halted parser swallows bytes
  a_halt_quiet: assert property (@(posedge clk) disable iff (rst)
    (in_accept && halted && !cfg_write) |=> !out_valid)
    else $error("result produced while halted");
`endif

endmodule
